/* sv/dlcw_pkg.sv */
package dlcw_pkg;

    // memory map and walk limits
    localparam int unsigned RAM_BYTES   = 2097152;
    localparam int unsigned NODE_LIMIT  = 524288;
    localparam int unsigned NODE_ADDR_W = $clog2(RAM_BYTES);
    localparam int unsigned SUM_W       = NODE_ADDR_W + 2;
    localparam int unsigned VISIT_W     = $clog2(NODE_LIMIT + 1);
    localparam int unsigned RD_ADDR_W   = 21;
    localparam int unsigned CFG_W       = 11;

    localparam logic [23:0] TERMINATOR  = 24'hFFFFFF;
    localparam logic [23:0] NODE_ADDR_MAX = 24'(RAM_BYTES - 4);

    // request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_ENV    = 2'd1;
    localparam logic [1:0] KIND_PACKET = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    // configuration register indexes
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    // command codes
    localparam logic [7:0] CMD_NOP       = 8'h00;
    localparam logic [7:0] CMD_NOP_ALT   = 8'h01;
    localparam logic [7:0] CMD_ENV_FIRST = 8'hE1;
    localparam logic [7:0] CMD_ENV_LAST  = 8'hE5;
    localparam logic [7:0] CMD_ENV_SKIP  = 8'hE6;
    localparam logic [7:0] CMD_COPY      = 8'h80;

    typedef struct packed {
        logic [1:0]           result_kind;
        logic [RD_ADDR_W-1:0] read_address;
        logic [31:0]          out_word;
        logic [3:0]           packet_length;
        logic                 packet_first;
        logic                 packet_last;
        logic                 walk_ok;
        logic                 last_of_run;
    } t_result;

    // results of one accepted item, slot 0 first
    typedef struct packed {
        logic [1:0]      n_res;
        t_result [1:0]   res;
    } t_step;

    // packet length in words, keyed on the command with its low two bits cleared
    function automatic logic [3:0] packet_words(input logic [7:0] cmd);
        logic [3:0] len;
        unique case ({cmd[7:2], 2'b00})
            8'h20: len = 4'd4;
            8'h24: len = 4'd7;
            8'h28: len = 4'd5;
            8'h2C: len = 4'd9;
            8'h30: len = 4'd6;
            8'h34: len = 4'd9;
            8'h38: len = 4'd8;
            8'h3C: len = 4'd12;
            8'h60: len = 4'd3;
            8'h64: len = 4'd4;
            8'h68: len = 4'd2;
            8'h70: len = 4'd2;
            8'h78: len = 4'd2;
            8'h74: len = 4'd3;
            8'h7C: len = 4'd3;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic t_result mk_read(input logic [RD_ADDR_W-1:0] addr);
        t_result r;
        r              = '0;
        r.result_kind  = KIND_READ;
        r.read_address = addr;
        return r;
    endfunction

    function automatic t_result mk_finish(input logic ok);
        t_result r;
        r             = '0;
        r.result_kind = KIND_FINISH;
        r.walk_ok     = ok;
        return r;
    endfunction

    function automatic t_result mk_word(input logic [1:0] kind, input logic [31:0] w,
                                        input logic [3:0] len, input logic first,
                                        input logic last);
        t_result r;
        r               = '0;
        r.result_kind   = kind;
        r.out_word      = w;
        r.packet_length = len;
        r.packet_first  = first;
        r.packet_last   = last;
        return r;
    endfunction

endpackage

/* sv/dlcw_in_if.sv */
interface dlcw_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] start_address;
    logic [31:0] read_data;

    modport source (output valid, output req_type, output start_address, output read_data,
                    input ready);
    modport sink   (input valid, input req_type, input start_address, input read_data,
                    output ready);
endinterface

/* sv/dlcw_out_if.sv */
interface dlcw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [20:0] read_address;
    logic [31:0] out_word;
    logic [3:0]  packet_length;
    logic        packet_first;
    logic        packet_last;
    logic        walk_ok;
    logic        last_of_run;

    modport source (output valid, output result_kind, output read_address, output out_word,
                    output packet_length, output packet_first, output packet_last,
                    output walk_ok, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input read_address, input out_word,
                    input packet_length, input packet_first, input packet_last,
                    input walk_ok, input last_of_run, output ready);
endinterface

/* sv/dlcw_walker.sv */
module dlcw_walker
    import dlcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_req_type,
    input  logic [31:0] i_start_address,
    input  logic [31:0] i_read_data,
    output t_step       o_step
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TAG,
        PH_BODY,
        PH_PKT,
        PH_CSRC,
        PH_CTGT
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [NODE_ADDR_W-1:0] r_node_addr, n_node_addr;
    logic [23:0]            r_next_addr, n_next_addr;
    logic [7:0]             r_word_count, n_word_count;
    logic [7:0]             r_word_offset, n_word_offset;
    logic [3:0]             r_pkt_left, n_pkt_left;
    logic [3:0]             r_pkt_len, n_pkt_len;
    logic [VISIT_W-1:0]     r_nodes_visited, n_nodes_visited;
    logic [31:0]            r_copy_src, n_copy_src;

    logic [7:0]       cmd;
    logic [7:0]       left;
    logic [3:0]       tbl_len;
    logic [SUM_W-1:0] tag_end;
    logic [SUM_W-1:0] body_addr;
    logic             res_a_vld, res_b_vld;
    t_result          res_a, res_b;
    logic             do_fetch, do_enter, fin_req, fin_ok;
    logic [23:0]      enter_addr;

    assign cmd     = i_read_data[31:24];
    assign left    = r_word_count - r_word_offset;
    assign tbl_len = packet_words(cmd);
    assign tag_end = SUM_W'(r_node_addr) + SUM_W'(4) + {{(SUM_W-10){1'b0}}, cmd, 2'b00};

    // next state and results of one item
    always_comb begin
        n_phase         = r_phase;
        n_node_addr     = r_node_addr;
        n_next_addr     = r_next_addr;
        n_word_count    = r_word_count;
        n_word_offset   = r_word_offset;
        n_pkt_left      = r_pkt_left;
        n_pkt_len       = r_pkt_len;
        n_nodes_visited = r_nodes_visited;
        n_copy_src      = r_copy_src;
        res_a_vld       = 1'b0;
        res_a           = '0;
        res_b_vld       = 1'b0;
        res_b           = '0;
        do_fetch        = 1'b0;
        do_enter        = 1'b0;
        fin_req         = 1'b0;
        fin_ok          = 1'b0;
        enter_addr      = i_start_address[23:0];
        body_addr       = '0;

        if (i_accept) begin
            if (i_req_type == REQ_START) begin
                n_nodes_visited = '0;
                n_word_offset   = '0;
                n_word_count    = '0;
                n_pkt_left      = '0;
                n_pkt_len       = '0;
                do_enter        = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_TAG: begin
                        if (tag_end > SUM_W'(RAM_BYTES)) begin
                            fin_req = 1'b1;
                        end else begin
                            n_word_count  = cmd;
                            n_next_addr   = i_read_data[23:0];
                            n_word_offset = '0;
                            n_phase       = PH_BODY;
                            do_fetch      = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        priority if (cmd >= CMD_ENV_FIRST && cmd <= CMD_ENV_LAST) begin
                            res_a_vld     = 1'b1;
                            res_a         = mk_word(KIND_ENV, i_read_data, 4'd0, 1'b0, 1'b0);
                            n_word_offset = r_word_offset + 8'd1;
                            do_fetch      = 1'b1;
                        end else if (cmd == CMD_NOP || cmd == CMD_NOP_ALT ||
                                     (cmd == CMD_ENV_SKIP && i_read_data[1:0] == 2'b00)) begin
                            n_word_offset = r_word_offset + 8'd1;
                            do_fetch      = 1'b1;
                        end else if (cmd == CMD_COPY) begin
                            if (left < 8'd4) begin
                                fin_req = 1'b1;
                            end else begin
                                n_phase       = PH_CSRC;
                                n_word_offset = r_word_offset + 8'd1;
                                do_fetch      = 1'b1;
                            end
                        end else if (tbl_len == 4'd0 || 8'(tbl_len) > left) begin
                            fin_req = 1'b1;
                        end else begin
                            n_pkt_len     = tbl_len;
                            n_pkt_left    = tbl_len - 4'd1;
                            res_a_vld     = 1'b1;
                            res_a         = mk_word(KIND_PACKET, i_read_data, tbl_len, 1'b1,
                                                    tbl_len == 4'd1);
                            n_word_offset = r_word_offset + 8'd1;
                            n_phase       = (tbl_len == 4'd1) ? PH_BODY : PH_PKT;
                            do_fetch      = 1'b1;
                        end
                    end
                    PH_PKT: begin
                        n_pkt_left    = r_pkt_left - 4'd1;
                        res_a_vld     = 1'b1;
                        res_a         = mk_word(KIND_PACKET, i_read_data, r_pkt_len, 1'b0,
                                                n_pkt_left == 4'd0);
                        n_word_offset = r_word_offset + 8'd1;
                        if (n_pkt_left == 4'd0) begin
                            n_phase = PH_BODY;
                        end
                        do_fetch = 1'b1;
                    end
                    PH_CSRC: begin
                        n_copy_src    = i_read_data;
                        n_phase       = PH_CTGT;
                        n_word_offset = r_word_offset + 8'd1;
                        do_fetch      = 1'b1;
                    end
                    PH_CTGT: begin
                        if (i_read_data != r_copy_src) begin
                            fin_req = 1'b1;
                        end else begin
                            n_word_offset = r_word_offset + 8'd2;
                            n_phase       = PH_BODY;
                            do_fetch      = 1'b1;
                        end
                    end
                    default: begin
                        // read data while idle is dropped
                    end
                endcase
            end
        end

        // request the next body word, or move on to the next node
        if (do_fetch) begin
            if (n_word_offset < n_word_count) begin
                body_addr = SUM_W'(r_node_addr) + SUM_W'(4)
                          + {{(SUM_W-10){1'b0}}, n_word_offset, 2'b00};
                res_b_vld = 1'b1;
                res_b     = mk_read(RD_ADDR_W'(body_addr));
            end else begin
                do_enter   = 1'b1;
                enter_addr = n_next_addr;
            end
        end

        // node entry checks
        if (do_enter) begin
            if (enter_addr == TERMINATOR) begin
                fin_req = 1'b1;
                fin_ok  = 1'b1;
            end else if (enter_addr[1:0] != 2'b00 || enter_addr > NODE_ADDR_MAX ||
                         n_nodes_visited >= VISIT_W'(NODE_LIMIT)) begin
                fin_req = 1'b1;
            end else begin
                n_nodes_visited = n_nodes_visited + VISIT_W'(1);
                n_node_addr     = enter_addr[NODE_ADDR_W-1:0];
                n_phase         = PH_TAG;
                res_b_vld       = 1'b1;
                res_b           = mk_read(RD_ADDR_W'(enter_addr));
            end
        end

        // walk end
        if (fin_req) begin
            n_phase   = PH_IDLE;
            res_b_vld = 1'b1;
            res_b     = mk_finish(fin_ok);
        end
    end

    // pack the results, the last one marked
    always_comb begin
        o_step = '0;
        if (res_a_vld && res_b_vld) begin
            o_step.n_res              = 2'd2;
            o_step.res[0]             = res_a;
            o_step.res[1]             = res_b;
            o_step.res[1].last_of_run = 1'b1;
        end else if (res_a_vld || res_b_vld) begin
            o_step.n_res              = 2'd1;
            o_step.res[0]             = res_a_vld ? res_a : res_b;
            o_step.res[0].last_of_run = 1'b1;
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_node_addr     <= '0;
            r_next_addr     <= '0;
            r_word_count    <= '0;
            r_word_offset   <= '0;
            r_pkt_left      <= '0;
            r_pkt_len       <= '0;
            r_nodes_visited <= '0;
            r_copy_src      <= '0;
        end else begin
            r_phase         <= n_phase;
            r_node_addr     <= n_node_addr;
            r_next_addr     <= n_next_addr;
            r_word_count    <= n_word_count;
            r_word_offset   <= n_word_offset;
            r_pkt_left      <= n_pkt_left;
            r_pkt_len       <= n_pkt_len;
            r_nodes_visited <= n_nodes_visited;
            r_copy_src      <= n_copy_src;
        end
    end

endmodule

/* sv/display_list_chain_walker.sv */
// channel   modport   payload                                       transfer when
// i_req     sink      req_type, start_address, read_data            valid && ready
// o_res     source    result_kind, read_address, out_word, packet   valid && ready
//                     length/first/last, walk_ok, last_of_run
// i_cfg     write     i_cfg_we, i_cfg_index, i_cfg_wdata            i_cfg_we
//
// each request is decoded in the cycle it transfers; its zero to two results land
// in a four-entry result queue and leave at one per cycle while o_res.ready is high
// one request per cycle while each request yields at most one result and o_res.ready
// is high; a request with two results (forwarded word plus next read or finish) puts
// both in the queue; i_req.ready drops while fewer than two queue entries are free
// synchronous active-low reset empties the queue and returns the walk to idle
module display_list_chain_walker
    import dlcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dlcw_in_if.sink          i_req,
    dlcw_out_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic             accept;
    logic             pop;
    t_step            step;

    // drawing origin, written through the configuration port
    logic [CFG_W-1:0] r_draw_origin_x;
    logic [CFG_W-1:0] r_draw_origin_y;

    t_result          r_fifo [4];
    logic [1:0]       r_wr_ptr, r_rd_ptr;
    logic [2:0]       r_count;
    logic [2:0]       n_count;
    t_result          head;

    assign i_req.ready = (r_count <= 3'd2);
    assign accept      = i_req.valid && i_req.ready;
    assign pop         = o_res.valid && o_res.ready;

    dlcw_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_req_type      (i_req.req_type),
        .i_start_address (i_req.start_address),
        .i_read_data     (i_req.read_data),
        .o_step          (step)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_origin_x <= '0;
            r_draw_origin_y <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ORIGIN_X) begin
                r_draw_origin_x <= i_cfg_wdata;
            end
            if (i_cfg_index == CFG_ORIGIN_Y) begin
                r_draw_origin_y <= i_cfg_wdata;
            end
        end
    end

    // result queue pointers
    assign n_count = r_count + (accept ? {1'b0, step.n_res} : 3'd0) - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + step.n_res;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (accept && step.n_res != 2'd0) begin
            r_fifo[r_wr_ptr] <= step.res[0];
        end
        if (accept && step.n_res == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= step.res[1];
        end
    end

    // output side
    assign head                = r_fifo[r_rd_ptr];
    assign o_res.valid         = (r_count != 3'd0);
    assign o_res.result_kind   = head.result_kind;
    assign o_res.read_address  = head.read_address;
    assign o_res.out_word      = head.out_word;
    assign o_res.packet_length = head.packet_length;
    assign o_res.packet_first  = head.packet_first;
    assign o_res.packet_last   = head.packet_last;
    assign o_res.walk_ok       = head.walk_ok;
    assign o_res.last_of_run   = head.last_of_run;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // a start always yields a read or a finish
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.req_type == REQ_START |-> step.n_res == 2'd1)
        else $error("start produced no single result");

    // a walk end closes the run of its request
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.result_kind == KIND_FINISH |-> o_res.last_of_run)
        else $error("finish not last of run");

    // read requests are word aligned
    a_read_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.result_kind == KIND_READ |-> o_res.read_address[1:0] == 2'b00)
        else $error("unaligned read request");

endmodule
